>>> hw/rtl/owmm_pkg.sv
// owmm_pkg: shared types and constants of the omni wheel motor mixer
// no dependencies; imported by owmm_front, owmm_back and the top level
`default_nettype none

package owmm_pkg;

    // configuration register map
    localparam int NUM_REGS = 7;
    localparam int REG_IDX_W = 3;

    localparam logic [REG_IDX_W-1:0] REG_W0_X = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_W0_Y = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_W1_X = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_W1_Y = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_W2_X = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_W2_Y = 3'd5;
    localparam logic [REG_IDX_W-1:0] REG_GAIN = 3'd6;

    // reset values, as raw 16-bit patterns
    localparam logic [15:0] RST_W0_X = 16'h0000;
    localparam logic [15:0] RST_W0_Y = 16'h4000;
    localparam logic [15:0] RST_W1_X = 16'h376D;
    localparam logic [15:0] RST_W1_Y = 16'hE000;
    localparam logic [15:0] RST_W2_X = 16'hC893;
    localparam logic [15:0] RST_W2_Y = 16'hE000;
    localparam logic [15:0] RST_GAIN = 16'h0100;

    // wheel count and per-wheel result packing
    localparam int NUM_WHEELS = 3;
    localparam int WHEEL_W = 9;

    // coefficient bundle from the register file to the kinematics front
    typedef struct packed {
        logic [NUM_WHEELS-1:0][15:0] dir_x;
        logic [NUM_WHEELS-1:0][15:0] dir_y;
        logic [15:0]                 gain;
    } t_coef;

endpackage

`default_nettype wire

>>> hw/rtl/owmm_fifo.sv
// owmm_fifo: small register-based word queue with occupancy count
// no dependencies; DEPTH must be a power of two
`default_nettype none

module owmm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_push,
    input  wire  [WIDTH-1:0]          i_wdata,
    input  wire                       i_pop,
    output logic [WIDTH-1:0]          o_rdata,
    output logic                      o_empty,
    output logic                      o_full,
    output logic [$clog2(DEPTH):0]    o_count
);
    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr;
    logic [AW-1:0]    r_rd_ptr;
    logic [AW:0]      r_count;
    logic             w_do_push;
    logic             w_do_pop;

    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    // storage
    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    // pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({w_do_push, w_do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_rdata = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == (AW+1)'(DEPTH));
    assign o_count = r_count;

endmodule

`default_nettype wire

>>> hw/rtl/owmm_front.sv
// owmm_front: kinematics front, wheel speeds, magnitudes and scaling divisor
// depends on owmm_pkg; writes into the middle queue under credit control
`default_nettype none

module owmm_front #(
    parameter int COEFF_FRAC_BITS = 14,
    parameter int MID_DEPTH = 8
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_push,
    output logic                                  o_full,
    input  wire  signed [7:0]                     i_move_x,
    input  wire  signed [7:0]                     i_move_y,
    input  wire  signed [7:0]                     i_turn_rate,
    input  wire                                   i_omni_mode,
    input  owmm_pkg::t_coef                       i_coef,
    input  wire  [$clog2(MID_DEPTH):0]            i_mid_count,
    output logic                                  o_mid_push,
    output logic [4*(COEFF_FRAC_BITS+26)+2:0]     o_mid_data
);
    import owmm_pkg::*;

    localparam int SW = COEFF_FRAC_BITS + 26;
    localparam int CW = $clog2(MID_DEPTH) + 1;
    localparam logic [SW-1:0] LIM = SW'(100) << (COEFF_FRAC_BITS + 8);

    logic               w_accept;
    logic [CW-1:0]      r_inflight;
    logic [CW:0]        w_used;
    logic [4:0]         r_vld;

    // stage 1 products
    logic signed [23:0] r_px [NUM_WHEELS];
    logic signed [23:0] r_py [NUM_WHEELS];
    logic signed [23:0] r_prot;
    logic               r_omni;
    // stage 2 speeds
    logic signed [SW-1:0] r_s [NUM_WHEELS];
    // stage 3 magnitudes
    logic [SW-1:0]      r_mag3 [NUM_WHEELS];
    logic [NUM_WHEELS-1:0] r_neg3;
    // stage 4 partial max
    logic [SW-1:0]      r_mag4 [NUM_WHEELS];
    logic [NUM_WHEELS-1:0] r_neg4;
    logic [SW-1:0]      r_m01;
    // stage 5 divisor
    logic [SW-1:0]      r_mag5 [NUM_WHEELS];
    logic [NUM_WHEELS-1:0] r_neg5;
    logic [SW-1:0]      r_den;
    logic [SW-1:0]      w_m2;

    // credit check against the middle queue
    assign w_used   = (CW+1)'(r_inflight) + (CW+1)'(i_mid_count);
    assign o_full   = (w_used >= (CW+1)'(MID_DEPTH));
    assign w_accept = i_push && !o_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= '0;
            r_inflight <= '0;
        end else begin
            r_vld <= {r_vld[3:0], w_accept};
            case ({w_accept, r_vld[4]})
                2'b10:   r_inflight <= r_inflight + 1'b1;
                2'b01:   r_inflight <= r_inflight - 1'b1;
                default: r_inflight <= r_inflight;
            endcase
        end
    end

    // stage 1: one 8x16 product per term
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NUM_WHEELS; i++) begin
            r_px[i] <= i_move_x * $signed(i_coef.dir_x[i]);
            r_py[i] <= (i_omni_mode ? i_move_y : i_turn_rate) * $signed(i_coef.dir_y[i]);
        end
        r_prot <= i_turn_rate * $signed(i_coef.gain);
        r_omni <= i_omni_mode;
    end

    // stage 2: wheel speed scaled by 2^(frac+8)
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NUM_WHEELS; i++) begin
            r_s[i] <= ((SW'(25'(r_px[i]) + 25'(r_py[i]))) <<< 8)
                    + (r_omni ? (SW'(r_prot) <<< COEFF_FRAC_BITS) : '0);
        end
    end

    // stage 3: sign and magnitude
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NUM_WHEELS; i++) begin
            r_neg3[i] <= r_s[i][SW-1];
            r_mag3[i] <= r_s[i][SW-1] ? $unsigned(-r_s[i]) : $unsigned(r_s[i]);
        end
    end

    // stage 4: max of the first two wheels
    always_ff @(posedge i_clk) begin
        r_mag4 <= r_mag3;
        r_neg4 <= r_neg3;
        r_m01  <= (r_mag3[0] > r_mag3[1]) ? r_mag3[0] : r_mag3[1];
    end

    // stage 5: divisor is the larger of the max and the limit
    assign w_m2 = (r_m01 > r_mag4[2]) ? r_m01 : r_mag4[2];
    always_ff @(posedge i_clk) begin
        r_mag5 <= r_mag4;
        r_neg5 <= r_neg4;
        r_den  <= (w_m2 > LIM) ? w_m2 : LIM;
    end

    assign o_mid_push = r_vld[4];
    assign o_mid_data = {r_neg5, r_den, r_mag5[2], r_mag5[1], r_mag5[0]};

endmodule

`default_nettype wire

>>> hw/rtl/owmm_back.sv
// owmm_back: pipelined restoring divider, pwm = floor(mag*255/den)
// depends on owmm_pkg; reads the middle queue, writes the result queue
`default_nettype none

module owmm_back #(
    parameter int COEFF_FRAC_BITS = 14,
    parameter int OUT_DEPTH = 16
) (
    input  wire                                   i_clk,
    input  wire                                   i_rst_n,
    input  wire                                   i_mid_empty,
    input  wire  [4*(COEFF_FRAC_BITS+26)+2:0]     i_mid_data,
    output logic                                  o_mid_pop,
    input  wire  [$clog2(OUT_DEPTH):0]            i_out_count,
    output logic                                  o_out_push,
    output logic [3*owmm_pkg::WHEEL_W-1:0]        o_out_data
);
    import owmm_pkg::*;

    localparam int SW = COEFF_FRAC_BITS + 26;
    localparam int NW = SW + 8;
    localparam int CW = $clog2(OUT_DEPTH) + 1;
    localparam int NST = 9;

    logic [CW-1:0]      r_inflight;
    logic [CW:0]        w_used;
    logic [NST-1:0]     r_vld;

    logic [NW-1:0]      r_rem [NST][NUM_WHEELS];
    logic [7:0]         r_q   [NST][NUM_WHEELS];
    logic [NUM_WHEELS-1:0] r_neg [NST];
    logic [SW-1:0]      r_den [NST];

    // credit check against the result queue
    assign w_used    = (CW+1)'(r_inflight) + (CW+1)'(i_out_count);
    assign o_mid_pop = !i_mid_empty && (w_used < (CW+1)'(OUT_DEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld      <= '0;
            r_inflight <= '0;
        end else begin
            r_vld <= {r_vld[NST-2:0], o_mid_pop};
            case ({o_mid_pop, r_vld[NST-1]})
                2'b10:   r_inflight <= r_inflight + 1'b1;
                2'b01:   r_inflight <= r_inflight - 1'b1;
                default: r_inflight <= r_inflight;
            endcase
        end
    end

    // load: dividend mag*255 as (mag<<8) - mag
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NUM_WHEELS; i++) begin
            r_rem[0][i] <= (NW'(i_mid_data[SW*i +: SW]) << 8) - NW'(i_mid_data[SW*i +: SW]);
            r_q[0][i]   <= '0;
        end
        r_den[0] <= i_mid_data[3*SW +: SW];
        r_neg[0] <= i_mid_data[4*SW +: NUM_WHEELS];
    end

    // one quotient bit per stage, most significant first
    for (genvar k = 1; k < NST; k++) begin : g_div
        localparam int B = NST - 1 - k;
        logic [NW-1:0] w_trial;
        assign w_trial = NW'(r_den[k-1]) << B;
        always_ff @(posedge i_clk) begin
            for (int i = 0; i < NUM_WHEELS; i++) begin
                if (r_rem[k-1][i] >= w_trial) begin
                    r_rem[k][i]  <= r_rem[k-1][i] - w_trial;
                    r_q[k][i]    <= r_q[k-1][i] | (8'd1 << B);
                end else begin
                    r_rem[k][i]  <= r_rem[k-1][i];
                    r_q[k][i]    <= r_q[k-1][i];
                end
            end
            r_den[k] <= r_den[k-1];
            r_neg[k] <= r_neg[k-1];
        end
    end

    // result word, a zero speed is never negative
    assign o_out_push = r_vld[NST-1];
    always_comb begin
        for (int i = 0; i < NUM_WHEELS; i++) begin
            o_out_data[WHEEL_W*i +: WHEEL_W] = {r_neg[NST-1][i], r_q[NST-1][i]};
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/omni_wheel_motor_mixer.sv
// omni_wheel_motor_mixer: top level, register file, queues, front and back
// depends on owmm_pkg, owmm_fifo, owmm_front, owmm_back
//
// Usage: motion commands go in through a queue-style port (push/full); a
// command is taken when push is high and full is low. Results come out of a
// queue (empty/pop): the oldest result sits on o_dir*/o_pwm* while empty is
// low and is taken when pop is high. Coefficients are written through the
// config channel (i_cfg_valid/o_cfg_ready, always ready); the user must write
// them only while the block is idle, as the block does not enforce this;
// writes to indexes past the register list are dropped. A command passes the
// kinematics stages, the middle queue and the divider stages before it is
// written into the result queue and empty goes low. Throughput: one command
// per cycle while neither queue backs up, set by the one-bit-per-stage
// divider pipeline and the two credit-checked queues.
// Reset clears both queues and loads the default wheel geometry.
// When the receiver stalls, the result queue (16 words) fills, the divider
// stops pulling from the middle queue (8 words), and full rises once the
// middle queue and the kinematics stages hold 8 commands.
`default_nettype none

module omni_wheel_motor_mixer #(
    parameter int COEFF_FRAC_BITS = 14
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               push,
    output logic              full,
    input  wire  signed [7:0] i_move_x,
    input  wire  signed [7:0] i_move_y,
    input  wire  signed [7:0] i_turn_rate,
    input  wire               i_omni_mode,
    output logic              empty,
    input  wire               pop,
    output logic              o_dir0,
    output logic [7:0]        o_pwm0,
    output logic              o_dir1,
    output logic [7:0]        o_pwm1,
    output logic              o_dir2,
    output logic [7:0]        o_pwm2,
    input  wire               i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire  [owmm_pkg::REG_IDX_W-1:0] i_cfg_index,
    input  wire  [15:0]       i_cfg_data
);
    import owmm_pkg::*;

    localparam int SW = COEFF_FRAC_BITS + 26;
    localparam int MID_W = 4*SW + 3;
    localparam int MID_DEPTH = 8;
    localparam int OUT_DEPTH = 16;
    localparam int OUT_W = 3*WHEEL_W;

    logic [15:0]        r_cfg [NUM_REGS];
    t_coef              w_coef;

    logic               w_mid_push;
    logic [MID_W-1:0]   w_mid_wdata;
    logic               w_mid_pop;
    logic [MID_W-1:0]   w_mid_rdata;
    logic               w_mid_empty;
    logic               w_mid_full;
    logic [$clog2(MID_DEPTH):0] w_mid_count;

    logic               w_out_push;
    logic [OUT_W-1:0]   w_out_wdata;
    logic [OUT_W-1:0]   w_out_rdata;
    logic               w_out_full;
    logic [$clog2(OUT_DEPTH):0] w_out_count;

    // coefficient registers
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg[REG_W0_X] <= RST_W0_X;
            r_cfg[REG_W0_Y] <= RST_W0_Y;
            r_cfg[REG_W1_X] <= RST_W1_X;
            r_cfg[REG_W1_Y] <= RST_W1_Y;
            r_cfg[REG_W2_X] <= RST_W2_X;
            r_cfg[REG_W2_Y] <= RST_W2_Y;
            r_cfg[REG_GAIN] <= RST_GAIN;
        end else if (i_cfg_valid && o_cfg_ready && (i_cfg_index <= REG_GAIN)) begin
            r_cfg[i_cfg_index] <= i_cfg_data;
        end
    end

    assign w_coef.dir_x[0] = r_cfg[REG_W0_X];
    assign w_coef.dir_y[0] = r_cfg[REG_W0_Y];
    assign w_coef.dir_x[1] = r_cfg[REG_W1_X];
    assign w_coef.dir_y[1] = r_cfg[REG_W1_Y];
    assign w_coef.dir_x[2] = r_cfg[REG_W2_X];
    assign w_coef.dir_y[2] = r_cfg[REG_W2_Y];
    assign w_coef.gain     = r_cfg[REG_GAIN];

    // kinematics front
    owmm_front #(
        .COEFF_FRAC_BITS(COEFF_FRAC_BITS),
        .MID_DEPTH      (MID_DEPTH)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .o_full     (full),
        .i_move_x   (i_move_x),
        .i_move_y   (i_move_y),
        .i_turn_rate(i_turn_rate),
        .i_omni_mode(i_omni_mode),
        .i_coef     (w_coef),
        .i_mid_count(w_mid_count),
        .o_mid_push (w_mid_push),
        .o_mid_data (w_mid_wdata)
    );

    // queue between front and back
    owmm_fifo #(
        .WIDTH(MID_W),
        .DEPTH(MID_DEPTH)
    ) u_mid_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_mid_push),
        .i_wdata(w_mid_wdata),
        .i_pop  (w_mid_pop),
        .o_rdata(w_mid_rdata),
        .o_empty(w_mid_empty),
        .o_full (w_mid_full),
        .o_count(w_mid_count)
    );

    // divider back
    owmm_back #(
        .COEFF_FRAC_BITS(COEFF_FRAC_BITS),
        .OUT_DEPTH      (OUT_DEPTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_mid_empty(w_mid_empty),
        .i_mid_data (w_mid_rdata),
        .o_mid_pop  (w_mid_pop),
        .i_out_count(w_out_count),
        .o_out_push (w_out_push),
        .o_out_data (w_out_wdata)
    );

    // result queue
    owmm_fifo #(
        .WIDTH(OUT_W),
        .DEPTH(OUT_DEPTH)
    ) u_out_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_out_push),
        .i_wdata(w_out_wdata),
        .i_pop  (pop),
        .o_rdata(w_out_rdata),
        .o_empty(empty),
        .o_full (w_out_full),
        .o_count(w_out_count)
    );

    assign {o_dir0, o_pwm0} = w_out_rdata[0*WHEEL_W +: WHEEL_W];
    assign {o_dir1, o_pwm1} = w_out_rdata[1*WHEEL_W +: WHEEL_W];
    assign {o_dir2, o_pwm2} = w_out_rdata[2*WHEEL_W +: WHEEL_W];

    // credit scheme must never overrun either queue
    a_mid_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mid_push |-> !w_mid_full)
        else $error("middle queue overrun");

    a_out_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_push |-> !w_out_full)
        else $error("result queue overrun");

    // back only pops a non-empty middle queue
    a_mid_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mid_pop |-> !w_mid_empty)
        else $error("middle queue underrun");

    // nothing comes out right after reset
    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> empty)
        else $error("results present after reset");

endmodule

`default_nettype wire
